// ===== design/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

  // Depth of the byte queue and of the result queue.
  localparam int unsigned QueueDepthDef = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_END        = 2'd1;
  localparam logic [1:0] ST_BAD_START  = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [21:0] MAX_CP         = 22'h10FFFF;
  localparam logic [21:0] SURR_LO        = 22'h00D800;
  localparam logic [21:0] SURR_HI        = 22'h00DFFF;

  // Byte classes found by the front end.
  typedef enum logic [1:0] {
    K_ZERO,
    K_CONT,
    K_ASCII,
    K_LEAD
  } kind_e;

  // One classified byte as it travels from the front end to the decoder.
  typedef struct packed {
    kind_e      kind;
    logic [6:0] bits;   // ASCII value, continuation payload or masked lead bits
    logic [1:0] extra;  // continuation bytes a lead byte announces
  } class_t;

  // One result as it waits in the result queue.
  typedef struct packed {
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // Sequence length from the upper nibble of a byte.
  function automatic logic [2:0] seq_len(input logic [3:0] nib);
    logic [2:0] n;
    unique case (nib)
      4'hC, 4'hD: n = 3'd2;
      4'hE:       n = 3'd3;
      4'hF:       n = 3'd4;
      4'h8, 4'h9, 4'hA, 4'hB: n = 3'd0;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  // Replace out-of-range values and surrogates with U+FFFD.
  function automatic logic [20:0] finish_code(input logic [21:0] c);
    logic [20:0] r;
    if (c > MAX_CP || (c >= SURR_LO && c <= SURR_HI)) begin
      r = REPLACEMENT_CP;
    end else begin
      r = c[20:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/u8d_fifo.sv =====
`default_nettype none

module u8d_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter type item_t = logic [7:0]
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/u8d_front.sv =====
`default_nettype none

module u8d_front (
  input  wire logic [7:0] in_byte_i,
  output u8d_pkg::class_t cls_o
);

  import u8d_pkg::*;

  logic [2:0] n;
  logic [7:0] mask;

  // Classify the byte and strip the length marker off lead bytes.
  always_comb begin
    n = seq_len(in_byte_i[7:4]);
    unique case (n)
      3'd2:    mask = 8'h3F;
      3'd3:    mask = 8'h1F;
      3'd4:    mask = 8'h0F;
      default: mask = 8'h7F;
    endcase

    cls_o.kind  = K_ASCII;
    cls_o.bits  = in_byte_i[6:0];
    cls_o.extra = '0;
    priority if (in_byte_i == 8'h00) begin
      cls_o.kind = K_ZERO;
    end else if (in_byte_i[7:6] == 2'b10) begin
      cls_o.kind = K_CONT;
      cls_o.bits = {1'b0, in_byte_i[5:0]};
    end else if (n == 3'd1) begin
      cls_o.kind = K_ASCII;
    end else begin
      cls_o.kind  = K_LEAD;
      cls_o.bits  = 7'(in_byte_i & mask);
      cls_o.extra = 2'(n - 3'd1);
    end
  end

endmodule

`default_nettype wire

// ===== design/u8d_back.sv =====
`default_nettype none

module u8d_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire u8d_pkg::class_t cls_i,
  input  wire logic        cls_empty_i,
  output logic             cls_pop_o,
  output u8d_pkg::result_t res_o,
  output logic             res_push_o,
  input  wire logic        res_full_i
);

  import u8d_pkg::*;

  logic [21:0] partial_q, partial_d;
  logic [1:0]  remain_q, remain_d;
  logic [21:0] grown;
  logic        take;

  assign take  = !cls_empty_i && !res_full_i;
  assign grown = {partial_q[15:0], cls_i.bits[5:0]};

  // Decode one classified byte against the open sequence.
  always_comb begin
    partial_d  = partial_q;
    remain_d   = remain_q;
    cls_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{code_point: '0, status: ST_OK, last: 1'b1};
    if (take) begin
      if (remain_q == 2'd0) begin
        // Byte in the start position.
        cls_pop_o = 1'b1;
        unique case (cls_i.kind)
          K_ZERO: begin
            res_push_o = 1'b1;
            res_o.status = ST_END;
          end
          K_CONT: begin
            res_push_o = 1'b1;
            res_o.status = ST_BAD_START;
          end
          K_ASCII: begin
            res_push_o = 1'b1;
            res_o.code_point = 21'(cls_i.bits);
          end
          K_LEAD: begin
            partial_d = 22'(cls_i.bits);
            remain_d  = cls_i.extra;
          end
          default: ;
        endcase
      end else begin
        unique case (cls_i.kind)
          K_CONT: begin
            cls_pop_o = 1'b1;
            partial_d = grown;
            remain_d  = remain_q - 2'd1;
            if (remain_q == 2'd1) begin
              res_push_o = 1'b1;
              res_o.code_point = finish_code(grown);
            end
          end
          K_ZERO: begin
            cls_pop_o  = 1'b1;
            remain_d   = '0;
            res_push_o = 1'b1;
            res_o.status = ST_INCOMPLETE;
          end
          K_ASCII: begin
            // Broken sequence; the byte stays at the head and is taken
            // again as a new start.
            remain_d   = '0;
            res_push_o = 1'b1;
            res_o.code_point = REPLACEMENT_CP;
            res_o.last = 1'b0;
          end
          K_LEAD: begin
            // Broken sequence; the new lead opens the next one at once.
            cls_pop_o  = 1'b1;
            partial_d  = 22'(cls_i.bits);
            remain_d   = cls_i.extra;
            res_push_o = 1'b1;
            res_o.code_point = REPLACEMENT_CP;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      remain_q  <= '0;
    end else begin
      partial_q <= partial_d;
      remain_q  <= remain_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/utf8_codepoint_decoder.sv =====
// UTF-8 decoder, one byte per item in, one code point or status per result.
// Input side is a queue: drive in_byte_i and raise push; the item is taken
// at a clock edge where push is high and full is low.
// Result side is a queue: while empty is low the oldest result sits on
// code_point_o, status_o and last_o; pop takes it. last_o marks the final
// result an input byte caused; a byte other than zero that breaks an open
// sequence gives U+FFFD first and may give a second result.
// Path: an accepted item is stored in the byte queue; the decoder takes it from
// the head and writes its first result to the result queue, where it appears
// on the result ports and can be popped.
// Throughput: one item per cycle while the result queue does not fill. A single-byte
// character that breaks an open sequence makes two results and holds the decoder
// for both, since the result queue takes one result per cycle.
// A stalled receiver fills the result queue, then the decoder stops, the
// byte queue fills and full rises; nothing is dropped.
// Reset empties both queues and leaves the decoder idle with no open
// sequence.
`default_nettype none

module utf8_codepoint_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8d_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [20:0]      code_point_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  import u8d_pkg::*;

  class_t  cls_in, cls_head;
  logic    cls_empty, cls_pop;
  result_t res_in, res_head;
  logic    res_push, res_full;

  // Front end: classify the incoming byte.
  u8d_front u_front (
    .in_byte_i (in_byte_i),
    .cls_o     (cls_in)
  );

  // Queue of classified bytes between front end and decoder.
  u8d_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (class_t)
  ) u_cls_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop),
    .data_o  (cls_head),
    .empty_o (cls_empty)
  );

  // Decoder: sequence state and result generation.
  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_head),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue toward the receiver.
  u8d_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (result_t)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign code_point_o = res_head.code_point;
  assign status_o     = res_head.status;
  assign last_o       = res_head.last;

  // Error and end results carry no code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (code_point_o == '0))
    else $error("non-ok result with nonzero code point");

  // A decoded code point is never a surrogate nor beyond the Unicode range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_OK) |->
      (code_point_o <= 21'h10FFFF && !(code_point_o >= 21'h00D800 &&
                                       code_point_o <= 21'h00DFFF)))
    else $error("code point out of range");

  // Only the replacement for a broken sequence is followed by a second result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (status_o == ST_OK && code_point_o == REPLACEMENT_CP))
    else $error("unexpected non-final result");

endmodule

`default_nettype wire

// ===== verif/u8d_decode_sb_pkg.sv =====
`timescale 1ns / 100ps

package u8d_decode_sb_pkg;

  import u8d_pkg::*;

  // Tracks the decoder state for every accepted byte and holds the results that are due.
  class utf8_decode_board;

    logic [21:0]  acc_code;
    logic [1:0]   conts_due;
    result_t      byte_results[$];
    result_t      due_results[$];
    int unsigned  bytes_taken;
    int unsigned  results_checked;
    int unsigned  mismatches;
    int unsigned  replacements;
    int unsigned  status_seen[4];

    function new();
      acc_code = '0;
      conts_due = '0;
      bytes_taken = 0;
      results_checked = 0;
      mismatches = 0;
      replacements = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void add_result(input logic [20:0] cp, input logic [1:0] st);
      result_t r;
      r.code_point = cp;
      r.status = st;
      r.last = 1'b0;
      byte_results.push_back(r);
    endfunction

    // A byte in the start position: end mark, stray continuation, ASCII or a lead byte.
    function void start_byte(input logic [7:0] b);
      int unsigned len;
      if (b == 8'h00) begin
        add_result('0, ST_END);
      end else if (b[7:6] == 2'b10) begin
        add_result('0, ST_BAD_START);
      end else begin
        case (b[7:4])
          4'hC, 4'hD: len = 2;
          4'hE:       len = 3;
          4'hF:       len = 4;
          default:    len = 1;
        endcase
        if (len == 1) begin
          add_result({13'd0, b}, ST_OK);
        end else begin
          // Lead bytes F8..FF keep four data bits, like F0..F7.
          acc_code = 22'(b & ((8'd1 << (8 - len)) - 8'd1));
          conts_due = 2'(len - 1);
        end
      end
    endfunction

    // Note an accepted byte and queue the results it should cause.
    function void take_byte(input logic [7:0] b);
      result_t r;
      byte_results.delete();
      bytes_taken++;
      if (conts_due == 2'd0) begin
        start_byte(b);
      end else if (b[7:6] == 2'b10) begin
        acc_code = {acc_code[15:0], b[5:0]};
        conts_due = conts_due - 2'd1;
        if (conts_due == 2'd0) begin
          if (acc_code > MAX_CP || (acc_code >= SURR_LO && acc_code <= SURR_HI)) begin
            add_result(REPLACEMENT_CP, ST_OK);
          end else begin
            add_result(acc_code[20:0], ST_OK);
          end
        end
      end else if (b == 8'h00) begin
        conts_due = 2'd0;
        add_result('0, ST_INCOMPLETE);
      end else begin
        // A non-continuation byte breaks the sequence and then starts anew.
        conts_due = 2'd0;
        add_result(REPLACEMENT_CP, ST_OK);
        start_byte(b);
      end
      foreach (byte_results[i]) begin
        r = byte_results[i];
        r.last = (i == byte_results.size() - 1);
        due_results.push_back(r);
      end
    endfunction

    // Compare one accepted result with the oldest one due.
    function void check_point(input logic [20:0] cp, input logic [1:0] st, input logic lst);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: code_point %h status %0d last %0b", cp, st, lst);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      results_checked++;
      status_seen[want.status]++;
      if (want.status == ST_OK && want.code_point == REPLACEMENT_CP) replacements++;
      if (cp !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, cp);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        mismatches++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

  endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  import u8d_pkg::*;
  import u8d_decode_sb_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomBytes = 450;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        empty;
  logic        pop;
  logic [20:0] dec_cp;
  logic [1:0]  dec_status;
  logic        dec_last;

  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;

  utf8_decode_board board;

  utf8_codepoint_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte),
    .empty        (empty),
    .pop          (pop),
    .code_point_o (dec_cp),
    .status_o     (dec_status),
    .last_o       (dec_last)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random at the current rate.
  always @(negedge clk_i) begin
    pop = ($urandom_range(0, 99) >= stall_pct);
  end

  // Check accepted results and watch for a stalled run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        board.check_point(dec_cp, dec_status, dec_last);
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Offer one item, with a random gap before it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    push = 1'b1;
    in_byte = b;
    do @(posedge clk_i); while (full);
    board.take_byte(b);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic send_lead_and_conts(input int unsigned len, input int unsigned conts);
    logic [7:0] lead;
    case (len)
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = ($urandom_range(0, 3) == 0) ? 8'hF8 | 8'($urandom_range(0, 7))
                                                  : 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    send_byte(lead);
    repeat (conts) send_byte(cont_byte());
  endtask

  // Mostly well-formed characters with random content, some broken ones and noise.
  task automatic send_chunk();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    len = $urandom_range(2, 4);
    if (pick < 30) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (pick < 72) begin
      send_lead_and_conts(len, len - 1);
    end else if (pick < 79) begin
      send_byte(8'h00);
    end else if (pick < 86) begin
      send_byte(cont_byte());
    end else if (pick < 94) begin
      // Cut a sequence short with a zero, an ASCII byte or a new lead.
      send_lead_and_conts(len, $urandom_range(0, len - 2));
      case ($urandom_range(0, 2))
        0:       send_byte(8'h00);
        1:       send_byte(8'($urandom_range(1, 127)));
        default: send_byte(8'hC0 | 8'($urandom_range(0, 63)));
      endcase
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    board = new();
    idle_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    push = 1'b0;
    in_byte = '0;
    pop = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes: end mark, stray continuation, ASCII, well-formed characters of each
    // length, the highest code point, a surrogate, an F8..FF lead, a sequence broken by an
    // ASCII byte, one broken by a new lead, and a zero inside a sequence.
    directed = '{8'h00, 8'hBF, 8'h7F,
                 8'hC3, 8'hA9,
                 8'hE2, 8'h82, 8'hAC,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 8'hED, 8'hA0, 8'h80,
                 8'hFF, 8'hBF, 8'hBF, 8'hBF,
                 8'hC3, 8'h41,
                 8'hE2, 8'hC3, 8'hA9,
                 8'hF0, 8'h9F, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    // Random bytes over four idling phases.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 60; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      while (board.bytes_taken < directed.size() + (p + 1) * RandomBytes / 4) send_chunk();
    end

    @(negedge clk_i);
    push = 1'b0;
    stall_pct = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Fed %0d bytes and checked %0d results: %0d code points (%0d replaced),",
             board.bytes_taken, board.results_checked, board.status_seen[ST_OK],
             board.replacements);
    $display("%0d end marks, %0d invalid starts, %0d incomplete sequences.",
             board.status_seen[ST_END], board.status_seen[ST_BAD_START],
             board.status_seen[ST_INCOMPLETE]);
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/u8d_pkg.sv
design/u8d_fifo.sv
design/u8d_front.sv
design/u8d_back.sv
design/utf8_codepoint_decoder.sv
verif/u8d_decode_sb_pkg.sv
verif/tb.sv
